@@ rtl/core/crrs_pkg.sv @@
// ----------------------------------------------------------------------------
// crrs_pkg: shared types and constants for the column-to-row span block
// field widths of the column and span transactions, and the sequencer phases
// ----------------------------------------------------------------------------
package crrs_pkg;

	localparam int X_W   = 11;
	localparam int TOP_W = 7;
	localparam int ROW_W = 6;

	typedef struct packed {
		logic [X_W-1:0]   column_x;
		logic [TOP_W-1:0] column_top;
		logic [ROW_W-1:0] column_bottom;
		logic             plane_start;
	} col_t;

	typedef struct packed {
		logic [ROW_W-1:0] span_row;
		logic [X_W-1:0]   span_first_x;
		logic [X_W-1:0]   span_end_x;
		logic             span_last;
	} span_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CLOSE_TOP,
		PH_CLOSE_BOT,
		PH_OPEN_TOP,
		PH_OPEN_BOT
	} phase_t;

endpackage

@@ rtl/core/crrs_if.sv @@
// ----------------------------------------------------------------------------
// crrs_if: valid/ready channels of the column-to-row span block
// one interface for incoming columns, one for outgoing row spans
// ----------------------------------------------------------------------------
interface crrs_col_if import crrs_pkg::*; ();
	logic valid;
	logic ready;
	col_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface crrs_span_if import crrs_pkg::*; ();
	logic  valid;
	logic  ready;
	span_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/crrs_ram.sv @@
// ----------------------------------------------------------------------------
// crrs_ram: generic simple dual-port ram
// one write port, one read port with registered read data held when idle
// ----------------------------------------------------------------------------
module crrs_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/column_runs_to_row_spans_top.sv @@
// ----------------------------------------------------------------------------
// column_runs_to_row_spans_top: per-column vertical extents to row spans
//
// col carries one column per transaction: x, top row, bottom row and a
// plane start flag; an empty column is top = ROWS, bottom = 0. span carries
// one finished row span per transaction (row, opening x, current x) and
// span_last marks the final span caused by a column. a column that closes
// no row produces no span transaction.
// a small sequencer walks the rows one per cycle: first closing rows from
// the old top down and the old bottom up, then recording the current x for
// newly opened rows. the opening columns sit in a ram of ROWS entries with
// one read and one write port. col is not ready until the column is done. a
// span shows in the cycle after its row is visited. when span stalls, the
// walk stops at the next closing row until the waiting span is taken;
// opening steps continue.
// reset marks the previous column empty; the ram needs no clearing pass.
// ----------------------------------------------------------------------------
module column_runs_to_row_spans_top import crrs_pkg::*; #(
	parameter int ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	crrs_col_if.sink           col,
	crrs_span_if.source        span
);

	localparam int AW = $clog2(ROWS);
	localparam logic [TOP_W-1:0] ROWS_V    = TOP_W'(ROWS);
	localparam logic [TOP_W-1:0] ROWS_M1_V = TOP_W'(ROWS - 1);
	localparam logic [TOP_W-1:0] ONE_V     = TOP_W'(1);

	phase_t state_q, state_d, act;

	logic [TOP_W-1:0] prev_top_q, prev_bottom_q;
	logic [TOP_W-1:0] t1_q, b1_q, t2_q, b2_q;
	logic [X_W-1:0]   x_q;

	logic [TOP_W-1:0] in_top, in_bottom;
	logic [TOP_W-1:0] t1p, b2p;
	logic             c_ct, c_cb, c_ot, c_ob;
	logic             at_ct, at_cb, at_ot, at_ob;
	logic             fire, accept;
	logic             step_ct, step_cb, step_ot, step_ob;
	logic             last_ct, last_cb;

	logic             span_valid_q;
	logic [ROW_W-1:0] span_row_q;
	logic [X_W-1:0]   span_end_q;
	logic             span_last_q;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [X_W-1:0]   ram_rdata;

	// clamp the incoming extents to the screen
	always_comb begin
		in_top    = (col.data.column_top > ROWS_V) ? ROWS_V : col.data.column_top;
		in_bottom = ({1'b0, col.data.column_bottom} > ROWS_M1_V) ? ROWS_M1_V
		            : {1'b0, col.data.column_bottom};
	end

	assign accept = col.valid && col.ready;
	assign fire   = !span_valid_q || span.ready;

	assign t1p = TOP_W'(t1_q + ONE_V);
	assign b2p = TOP_W'(b2_q + ONE_V);

	assign c_ct = (t1_q < t2_q) && (t1_q <= b1_q);
	assign c_cb = (b1_q > b2_q) && (b1_q >= t1_q);
	assign c_ot = (t2_q < t1_q) && (t2_q <= b2_q);
	assign c_ob = (b2_q > b1_q) && (b2_q >= t2_q);

	// lookahead: is this the final closing step of the column
	assign last_ct = !(((t1p < t2_q) && (t1p <= b1_q)) || ((b1_q > b2_q) && (b1_q >= t1p)));
	assign last_cb = !((b1_q > b2p) && (b1_q > t1_q));

	// first phase at or after the current one that still has work
	always_comb begin
		at_ct = (state_q == PH_CLOSE_TOP);
		at_cb = at_ct || (state_q == PH_CLOSE_BOT);
		at_ot = at_cb || (state_q == PH_OPEN_TOP);
		at_ob = at_ot || (state_q == PH_OPEN_BOT);
		if (at_ct && c_ct) begin
			act = PH_CLOSE_TOP;
		end else if (at_cb && c_cb) begin
			act = PH_CLOSE_BOT;
		end else if (at_ot && c_ot) begin
			act = PH_OPEN_TOP;
		end else if (at_ob && c_ob) begin
			act = PH_OPEN_BOT;
		end else begin
			act = PH_IDLE;
		end
	end

	// next state
	always_comb begin
		case (state_q)
			PH_IDLE: begin
				state_d = col.valid ? PH_CLOSE_TOP : PH_IDLE;
			end
			PH_CLOSE_TOP, PH_CLOSE_BOT, PH_OPEN_TOP, PH_OPEN_BOT: begin
				state_d = act;
			end
			default: begin
				state_d = PH_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		col.ready = (state_q == PH_IDLE);
		step_ct   = (act == PH_CLOSE_TOP) && fire;
		step_cb   = (act == PH_CLOSE_BOT) && fire;
		step_ot   = (act == PH_OPEN_TOP);
		step_ob   = (act == PH_OPEN_BOT);
		ram_re    = step_ct || step_cb;
		ram_raddr = step_ct ? t1_q[AW-1:0] : b1_q[AW-1:0];
		ram_we    = step_ot || step_ob;
		ram_waddr = step_ot ? t2_q[AW-1:0] : b2_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= PH_IDLE;
			prev_top_q    <= ROWS_V;
			prev_bottom_q <= '0;
			span_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_top_q    <= in_top;
				prev_bottom_q <= in_bottom;
			end
			if (step_ct || step_cb) begin
				span_valid_q <= 1'b1;
			end else if (span.ready) begin
				span_valid_q <= 1'b0;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= col.data.column_x;
			t2_q <= in_top;
			b2_q <= in_bottom;
			t1_q <= col.data.plane_start ? ROWS_V : prev_top_q;
			b1_q <= col.data.plane_start ? '0 : prev_bottom_q;
		end else begin
			if (step_ct) begin
				t1_q <= t1p;
			end
			if (step_cb) begin
				b1_q <= TOP_W'(b1_q - ONE_V);
			end
			if (step_ot) begin
				t2_q <= TOP_W'(t2_q + ONE_V);
			end
			if (step_ob) begin
				b2_q <= TOP_W'(b2_q - ONE_V);
			end
		end
		if (step_ct || step_cb) begin
			span_row_q  <= step_ct ? ROW_W'(t1_q) : ROW_W'(b1_q);
			span_end_q  <= x_q;
			span_last_q <= step_ct ? last_ct : last_cb;
		end
	end

	crrs_ram #(
		.WIDTH (X_W),
		.DEPTH (ROWS)
	) u_start_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (x_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign span.valid = span_valid_q;
	assign span.data  = '{span_row:     span_row_q,
	                      span_first_x: ram_rdata,
	                      span_end_x:   span_end_q,
	                      span_last:    span_last_q};

endmodule
